// ----- rtl/sof_oscillator_trim_search_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SOF_OSCILLATOR_TRIM_SEARCH_MACROS_SVH
`define SOF_OSCILLATOR_TRIM_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sof_oscillator_trim_search: assertion failed");

// Next-cycle implication, disabled during reset.
`define SOF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sof_oscillator_trim_search: assertion failed");

`endif

// ----- rtl/sof_ots_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sof_ots_pkg;

   localparam int COUNT_WIDTH  = 15;
   localparam int FINE_WIDTH   = 7;
   localparam int COARSE_WIDTH = 6;
   localparam int WINDOW_WIDTH = 14;
   localparam int MISS_WIDTH   = 32;
   localparam int STREAK_WIDTH = 4;
   localparam int WARMUP_WIDTH = 4;
   localparam int GRAD_WIDTH   = COUNT_WIDTH + 1;
   localparam int AMOUNT_WIDTH = 12;
   localparam int WORD_WIDTH   = COARSE_WIDTH + FINE_WIDTH;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COARSE_TRIM  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_FINE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTRE_COUNT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOCK_WINDOW  = 3'd3;

   // Reset values.
   localparam logic [COARSE_WIDTH-1:0] COARSE_RESET = 6'd0;
   localparam logic [FINE_WIDTH-1:0]   FINE_RESET   = 7'd64;
   localparam logic [COUNT_WIDTH-1:0]  CENTRE_RESET = 15'd12000;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 14'd1000;
   localparam logic [COUNT_WIDTH-1:0]  PREV_RESET   = 15'd12000;

   localparam logic [STREAK_WIDTH-1:0] STREAK_LENGTH = 4'd12;
   localparam logic [WARMUP_WIDTH-1:0] WARMUP_RESET  = 4'd10;
   localparam logic [WARMUP_WIDTH-1:0] WARMUP_RELOCK = 4'd6;

   // Gradient bands.
   localparam logic signed [GRAD_WIDTH-1:0] GRAD_NEG_FAR  = -16'sd150;
   localparam logic signed [GRAD_WIDTH-1:0] GRAD_NEG_NEAR = -16'sd50;
   localparam logic signed [GRAD_WIDTH-1:0] GRAD_POS_NEAR = 16'sd50;

   // Divide by 48: shift by 4, then multiply by the reciprocal of 3.
   localparam int DIV16_SHIFT  = 4;
   localparam int DIV3_IN_W    = COUNT_WIDTH - DIV16_SHIFT;
   localparam int DIV3_SHIFT   = 12;
   localparam int DIV3_PROD_W  = 22;
   localparam logic [DIV3_IN_W-1:0] DIV3_MAGIC = 11'd1366;

   localparam logic [WORD_WIDTH:0] WORD_MAX = 14'h1fff;

   localparam logic signed [AMOUNT_WIDTH-1:0] AMOUNT_ZERO = 12'sd0;
   localparam logic signed [AMOUNT_WIDTH-1:0] AMOUNT_UP   = 12'sd1;
   localparam logic signed [AMOUNT_WIDTH-1:0] AMOUNT_DOWN = -12'sd1;

   typedef enum logic [1:0] {
      PHASE_SEEK_NEG = 2'd0,
      PHASE_SEEK_POS = 2'd1,
      PHASE_MAINTAIN = 2'd2
   } phase_type;

   typedef struct packed {
      logic [COARSE_WIDTH-1:0] coarse_trim;
      logic [COUNT_WIDTH-1:0]  centre_count;
      logic [WINDOW_WIDTH-1:0] lock_window;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [STREAK_WIDTH-1:0] streak_left;
      logic [COUNT_WIDTH-1:0]  previous_count;
      logic [FINE_WIDTH-1:0]   negative_drift_trim;
      logic [FINE_WIDTH-1:0]   positive_drift_trim;
      logic [WARMUP_WIDTH-1:0] warmup_left;
      logic [MISS_WIDTH-1:0]   miss_counter;
      logic [FINE_WIDTH-1:0]   fine_trim;
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/sof_ots_trim_add.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Guarded add of a signed amount on the word {coarse, fine}.
module sof_ots_trim_add (
   input  wire logic [sof_ots_pkg::COARSE_WIDTH-1:0]        coarse_trim,
   input  wire logic [sof_ots_pkg::FINE_WIDTH-1:0]          fine_trim,
   input  wire logic signed [sof_ots_pkg::AMOUNT_WIDTH-1:0] amount,
   output logic      [sof_ots_pkg::FINE_WIDTH-1:0]          fine_out
);

   logic [sof_ots_pkg::WORD_WIDTH-1:0]   word;
   logic [sof_ots_pkg::AMOUNT_WIDTH-1:0] mag;
   logic [sof_ots_pkg::WORD_WIDTH:0]     sum;
   logic [sof_ots_pkg::WORD_WIDTH-1:0]   diff;
   logic                                 skip;

   assign word = {coarse_trim, fine_trim};
   assign mag  = amount[sof_ots_pkg::AMOUNT_WIDTH-1] ? (~amount + 1'b1) : amount;
   assign sum  = {1'b0, word} + {2'b00, mag};
   assign diff = word - {1'b0, mag};

   // Skip on zero, on underflow and on overflow, whatever the direction.
   assign skip = (amount == sof_ots_pkg::AMOUNT_ZERO)
              || ({2'b00, word} < {1'b0, mag})
              || (sum > sof_ots_pkg::WORD_MAX);

   always_comb begin
      if (skip) begin
         fine_out = fine_trim;
      end else if (amount[sof_ots_pkg::AMOUNT_WIDTH-1]) begin
         fine_out = diff[sof_ots_pkg::FINE_WIDTH-1:0];
      end else begin
         fine_out = sum[sof_ots_pkg::FINE_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sof_ots_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Next state for one start-of-frame count.
module sof_ots_step (
   input  wire sof_ots_pkg::cfg_type                  cfg,
   input  wire sof_ots_pkg::state_type                state,
   input  wire logic [sof_ots_pkg::COUNT_WIDTH-1:0]   frame_count,
   output sof_ots_pkg::state_type                     state_next,
   output logic                                       relock
);

   logic signed [sof_ots_pkg::GRAD_WIDTH-1:0]   grad;
   logic [sof_ots_pkg::GRAD_WIDTH-1:0]          grad_abs;
   logic [sof_ots_pkg::DIV3_IN_W-1:0]           div_in;
   logic [sof_ots_pkg::DIV3_PROD_W-1:0]         div_prod;
   logic [sof_ots_pkg::AMOUNT_WIDTH-1:0]        quot_mag;
   logic signed [sof_ots_pkg::AMOUNT_WIDTH-1:0] quot;
   logic signed [sof_ots_pkg::AMOUNT_WIDTH-1:0] seek_amount;
   logic signed [sof_ots_pkg::AMOUNT_WIDTH-1:0] add_amount;
   logic [sof_ots_pkg::FINE_WIDTH-1:0]          add_fine;
   logic                                        neg_band;
   logic                                        pos_band;
   logic [sof_ots_pkg::COUNT_WIDTH+1:0]         low_side;
   logic [sof_ots_pkg::COUNT_WIDTH+1:0]         high_edge;
   logic                                        out_of_window;

   assign grad = $signed({1'b0, frame_count}) - $signed({1'b0, state.previous_count});
   assign grad_abs = grad[sof_ots_pkg::GRAD_WIDTH-1] ? (~grad + 1'b1) : grad;

   // Truncating divide by 48 on the magnitude, sign restored after.
   assign div_in   = grad_abs[sof_ots_pkg::COUNT_WIDTH-1:sof_ots_pkg::DIV16_SHIFT];
   assign div_prod = sof_ots_pkg::DIV3_PROD_W'(div_in)
                   * sof_ots_pkg::DIV3_PROD_W'(sof_ots_pkg::DIV3_MAGIC);
   assign quot_mag = sof_ots_pkg::AMOUNT_WIDTH'(div_prod >> sof_ots_pkg::DIV3_SHIFT);
   assign quot     = grad[sof_ots_pkg::GRAD_WIDTH-1] ? -$signed(quot_mag) : $signed(quot_mag);

   assign seek_amount = ((grad < sof_ots_pkg::GRAD_NEG_FAR) ? sof_ots_pkg::AMOUNT_UP
                                                            : sof_ots_pkg::AMOUNT_DOWN) - quot;

   assign neg_band = (grad < sof_ots_pkg::GRAD_NEG_NEAR) && (grad > sof_ots_pkg::GRAD_NEG_FAR);
   assign pos_band = (grad > sof_ots_pkg::GRAD_POS_NEAR);

   assign low_side  = {2'b00, frame_count} + {3'b000, cfg.lock_window};
   assign high_edge = {2'b00, cfg.centre_count} + {3'b000, cfg.lock_window};
   assign out_of_window = (low_side < {2'b00, cfg.centre_count})
                       || ({2'b00, frame_count} > high_edge);

   // Pick the trim nudge; in positive seek, outside the positive band it is a step up.
   always_comb begin
      add_amount = sof_ots_pkg::AMOUNT_ZERO;
      unique case (state.phase)
         sof_ots_pkg::PHASE_SEEK_NEG: begin
            if (!neg_band) begin
               add_amount = seek_amount;
            end else if (state.streak_left == '0) begin
               add_amount = sof_ots_pkg::AMOUNT_UP;
            end
         end
         sof_ots_pkg::PHASE_SEEK_POS: begin
            if (!pos_band) begin
               add_amount = sof_ots_pkg::AMOUNT_UP;
            end
         end
         default: begin
            add_amount = sof_ots_pkg::AMOUNT_ZERO;
         end
      endcase
   end

   sof_ots_trim_add u_trim_add (
      .coarse_trim (cfg.coarse_trim),
      .fine_trim   (state.fine_trim),
      .amount      (add_amount),
      .fine_out    (add_fine)
   );

   always_comb begin
      state_next = state;
      relock     = 1'b0;
      unique case (state.phase)
         sof_ots_pkg::PHASE_SEEK_NEG: begin
            state_next.previous_count = frame_count;
            state_next.fine_trim      = add_fine;
            if (!neg_band) begin
               state_next.streak_left = sof_ots_pkg::STREAK_LENGTH;
            end else if (state.streak_left != '0) begin
               state_next.streak_left = state.streak_left - 1'b1;
            end else begin
               // Record the trim, then move to positive seek for the following counts.
               state_next.negative_drift_trim = state.fine_trim;
               state_next.phase               = sof_ots_pkg::PHASE_SEEK_POS;
               state_next.streak_left         = sof_ots_pkg::STREAK_LENGTH;
            end
         end
         sof_ots_pkg::PHASE_SEEK_POS: begin
            state_next.previous_count = frame_count;
            state_next.fine_trim      = add_fine;
            if (pos_band) begin
               if (state.streak_left != '0) begin
                  state_next.streak_left = state.streak_left - 1'b1;
               end else begin
                  state_next.positive_drift_trim = state.fine_trim;
                  state_next.phase               = sof_ots_pkg::PHASE_MAINTAIN;
               end
            end
         end
         sof_ots_pkg::PHASE_MAINTAIN: begin
            if (frame_count > cfg.centre_count) begin
               state_next.fine_trim = state.negative_drift_trim;
            end else if (frame_count < cfg.centre_count) begin
               state_next.fine_trim = state.positive_drift_trim;
            end
            if (state.warmup_left != '0) begin
               state_next.warmup_left = state.warmup_left - 1'b1;
            end else if (out_of_window) begin
               state_next.phase        = sof_ots_pkg::PHASE_SEEK_NEG;
               state_next.miss_counter = state.miss_counter + 1'b1;
               state_next.warmup_left  = sof_ots_pkg::WARMUP_RELOCK;
               relock                  = 1'b1;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/sof_oscillator_trim_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Start-of-frame oscillator trim search. Each req beat carries the reference
// timer count sampled at one USB start-of-frame; each rsp beat returns the fine
// trim after that frame, the search phase, the running miss total and a flag
// that marks a restart of the search. Throughput is one beat per cycle while
// rsp is not stalled; a beat lands in the input register, then is folded into
// the trim state and written to the result registers together. The step from
// input to state and result registers (one guarded 13-bit add and a divide
// by 48 done as a shift and an 11-bit reciprocal multiply) is combinational.
// The result register holds while rsp is stalled, and the input register still
// takes a beat then if it is empty. Configuration writes are always ready and
// are meant for idle periods only; writing the initial fine trim loads the live
// trim at once, but is dropped if a beat advances in that cycle. Reset sets the
// state to its reset values; there is no clearing pass.
module sof_oscillator_trim_search (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic [sof_ots_pkg::COUNT_WIDTH-1:0]       req_frame_count,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [sof_ots_pkg::FINE_WIDTH-1:0]             rsp_fine_trim_out,
   output logic [1:0]                                     rsp_search_phase,
   output logic [sof_ots_pkg::MISS_WIDTH-1:0]             rsp_miss_total,
   output logic                                           rsp_relock_flag,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [sof_ots_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [sof_ots_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   sof_ots_pkg::cfg_type   cfg_ff;
   sof_ots_pkg::cfg_type   cfg_in;
   sof_ots_pkg::state_type state_ff;
   sof_ots_pkg::state_type state_in;
   sof_ots_pkg::state_type state_step;

   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic [sof_ots_pkg::COUNT_WIDTH-1:0]   in_count_ff;

   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic [sof_ots_pkg::FINE_WIDTH-1:0]    rsp_fine_ff;
   logic [1:0]                            rsp_phase_ff;
   logic [sof_ots_pkg::MISS_WIDTH-1:0]    rsp_miss_ff;
   logic                                  rsp_relock_ff;

   logic step_relock;
   logic out_open;
   logic advance;
   logic req_take;
   logic csr_write;
   logic fine_write;

   // Handshake: the result register opens when empty or drained this cycle.
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Decode register writes; out-of-list indexes drop.
   always_comb begin
      cfg_in     = cfg_ff;
      fine_write = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            sof_ots_pkg::CSR_COARSE_TRIM: begin
               cfg_in.coarse_trim = csr_data[sof_ots_pkg::COARSE_WIDTH-1:0];
            end
            sof_ots_pkg::CSR_INITIAL_FINE: begin
               fine_write = 1'b1;
            end
            sof_ots_pkg::CSR_CENTRE_COUNT: begin
               cfg_in.centre_count = csr_data[sof_ots_pkg::COUNT_WIDTH-1:0];
            end
            sof_ots_pkg::CSR_LOCK_WINDOW: begin
               cfg_in.lock_window = csr_data[sof_ots_pkg::WINDOW_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   sof_ots_step u_step (
      .cfg         (cfg_ff),
      .state       (state_ff),
      .frame_count (in_count_ff),
      .state_next  (state_step),
      .relock      (step_relock)
   );

   // Advance the trim state with each beat; a fine trim write loads it directly when no beat advances.
   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = state_step;
      end else if (fine_write) begin
         state_in.fine_trim = csr_data[sof_ots_pkg::FINE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coarse_trim           <= sof_ots_pkg::COARSE_RESET;
         cfg_ff.centre_count          <= sof_ots_pkg::CENTRE_RESET;
         cfg_ff.lock_window           <= sof_ots_pkg::WINDOW_RESET;
         state_ff.phase               <= sof_ots_pkg::PHASE_SEEK_NEG;
         state_ff.streak_left         <= sof_ots_pkg::STREAK_LENGTH;
         state_ff.previous_count      <= sof_ots_pkg::PREV_RESET;
         state_ff.negative_drift_trim <= '0;
         state_ff.positive_drift_trim <= '0;
         state_ff.warmup_left         <= sof_ots_pkg::WARMUP_RESET;
         state_ff.miss_counter        <= '0;
         state_ff.fine_trim           <= sof_ots_pkg::FINE_RESET;
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on take or advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_count_ff <= req_frame_count;
      end
      if (advance) begin
         rsp_fine_ff   <= state_step.fine_trim;
         rsp_phase_ff  <= state_step.phase;
         rsp_miss_ff   <= state_step.miss_counter;
         rsp_relock_ff <= step_relock;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fine_trim_out = rsp_fine_ff;
   assign rsp_search_phase  = rsp_phase_ff;
   assign rsp_miss_total    = rsp_miss_ff;
   assign rsp_relock_flag   = rsp_relock_ff;

endmodule

`default_nettype wire

// ----- rtl/sof_ots_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "sof_oscillator_trim_search_macros.svh"

module sof_ots_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    req_valid,
   input wire logic                                    req_stall,
   input wire logic [sof_ots_pkg::COUNT_WIDTH-1:0]     req_frame_count,
   input wire logic                                    rsp_valid,
   input wire logic                                    rsp_stall,
   input wire logic [sof_ots_pkg::FINE_WIDTH-1:0]      rsp_fine_trim_out,
   input wire logic [1:0]                              rsp_search_phase,
   input wire logic [sof_ots_pkg::MISS_WIDTH-1:0]      rsp_miss_total,
   input wire logic                                    rsp_relock_flag,
   input wire logic                                    csr_valid,
   input wire logic                                    csr_ready,
   input wire logic [sof_ots_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [sof_ots_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic rsp_beat;
   logic rsp_beat_ff;
   logic back_to_back;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // Remember whether a result beat went out at the previous edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_beat_ff <= 1'b0;
      end else begin
         rsp_beat_ff <= rsp_beat;
      end
   end

   assign back_to_back = rsp_valid && rsp_beat_ff;

   // A stalled result holds.
   `SOF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_fine_trim_out) && $stable(rsp_miss_total))

   // A restart always lands in negative seek.
   `SOF_ASSERT_IMPLY(a_relock_phase, clock, reset, rsp_valid && rsp_relock_flag,
      rsp_search_phase == sof_ots_pkg::PHASE_SEEK_NEG)

   // Successive results: the miss total moves only with a restart, by one.
   `SOF_ASSERT_IMPLY(a_miss_steady, clock, reset, back_to_back && !rsp_relock_flag,
      rsp_miss_total == $past(rsp_miss_total))
   `SOF_ASSERT_IMPLY(a_miss_step, clock, reset, back_to_back && rsp_relock_flag,
      rsp_miss_total == $past(rsp_miss_total) + 1'b1)

endmodule

bind sof_oscillator_trim_search sof_ots_checker u_checker (.*);

`default_nettype wire
